@@ sv/aule_pkg.sv @@
// ----------------------------------------------------------------------------
// aule_pkg
// Shared types, constants and the step table of the upload limit estimator.
// ----------------------------------------------------------------------------
package aule_pkg;

	localparam int SLOT_W         = 7;
	localparam int RATE_W         = 32;
	localparam int LEVEL_W        = 9;
	localparam int WARMUP_W       = 20;
	localparam int CNT_W          = 16;
	localparam int RUN_W          = 4;
	localparam int DELTA_W        = 11;
	localparam int CFG_IDX_W      = 2;

	localparam logic [SLOT_W-1:0] SLOT_COUNT_MAX = 7'd64;

	// busy fraction: (busy << 5) / sendable
	localparam int FRAC_SHIFT     = 5;
	localparam int DVD_W          = SLOT_W + FRAC_SHIFT;
	localparam int FRAC_W         = FRAC_SHIFT + 1;
	localparam int DIV_CNT_W      = 4;
	localparam logic [FRAC_W-1:0] FRAC_HIGH = 6'd24;
	localparam logic [FRAC_W-1:0] FRAC_LOW  = 6'd8;
	localparam logic [SLOT_W-1:0] BUSY_FEW  = 7'd2;

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX      = 9'sd255;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN      = -9'sd255;
	localparam logic signed [LEVEL_W-1:0] LEVEL_HIGH     = 9'sd250;
	localparam logic signed [LEVEL_W-1:0] LEVEL_LOW      = -9'sd250;
	localparam logic signed [LEVEL_W-1:0] LEVEL_RESTART  = -9'sd200;
	localparam logic signed [LEVEL_W-1:0] LEVEL_ALL_BUSY = 9'sd125;

	localparam logic [RATE_W-1:0] EST_FLOOR = 32'd1024;
	localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;
	localparam logic [RUN_W-1:0]  RUN_MAX   = 4'd15;

	localparam logic [CNT_W-1:0] CHG_LIMIT     = 16'd500;
	localparam logic [CNT_W-1:0] CHG_LIMIT_MID = 16'd300;
	localparam logic [CNT_W-1:0] LOOP_LIMIT_MID = 16'd1000;
	localparam logic [CNT_W-1:0] LOOP_LIMIT    = 16'd2000;

	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SLOTS = 2'd2;

	localparam logic [WARMUP_W-1:0] WARMUP_RESET      = 20'd60000;
	localparam logic [SLOT_W-1:0]   START_SLOTS_RESET = 7'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic              sub;
		logic [RATE_W-1:0] a;
		logic [RATE_W-1:0] b;
	} addsub_req_t;

	function automatic logic [DELTA_W-1:0] step_delta(input logic [RUN_W-1:0] run);
		logic [DELTA_W-1:0] d;
		case (run)
			4'd0:    d = 11'd50;
			4'd1:    d = 11'd50;
			4'd2:    d = 11'd128;
			4'd3:    d = 11'd256;
			4'd4:    d = 11'd512;
			4'd5:    d = 11'd768;
			4'd6:    d = 11'd1024;
			4'd7:    d = 11'd1280;
			default: d = 11'd1536;
		endcase
		return d;
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (v != CNT_MAX) ? v + 16'd1 : v;
	endfunction

endpackage

@@ sv/aule_div.sv @@
// ----------------------------------------------------------------------------
// aule_div
// Restoring radix-2 divider for the busy fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module aule_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [aule_pkg::DVD_W-1:0]           dividend,
	input  logic [aule_pkg::SLOT_W-1:0]          divisor,
	output logic [aule_pkg::FRAC_W-1:0]          quotient,
	output aule_pkg::div_stat_t                  stat
);

	logic                               busy_q;
	logic                               done_q;
	logic [aule_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [aule_pkg::DVD_W-1:0]         quo_q;
	logic [aule_pkg::SLOT_W-1:0]        rem_q;
	logic [aule_pkg::SLOT_W-1:0]        dsr_q;
	logic [aule_pkg::SLOT_W:0]          trial;
	logic [aule_pkg::SLOT_W:0]          diff;
	logic                               ge;

	assign trial = {rem_q, quo_q[aule_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= aule_pkg::DIV_CNT_W'(aule_pkg::DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits SLOT_W bits
			rem_q <= ge ? diff[aule_pkg::SLOT_W-1:0] : trial[aule_pkg::SLOT_W-1:0];
			quo_q <= {quo_q[aule_pkg::DVD_W-2:0], ge};
		end
	end

	// busy <= sendable keeps the quotient at 32 or less
	assign quotient  = quo_q[aule_pkg::FRAC_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ sv/aule_addsub.sv @@
// ----------------------------------------------------------------------------
// aule_addsub
// Shared 32-bit adder/subtractor; bit 32 is carry on add, borrow on subtract.
// ----------------------------------------------------------------------------
module aule_addsub (
	input  aule_pkg::addsub_req_t          req,
	output logic [aule_pkg::RATE_W:0]      res
);

	always_comb begin
		if (req.sub) begin
			res = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			res = {1'b0, req.a} + {1'b0, req.b};
		end
	end

endmodule

@@ sv/adaptive_upload_limit_estimator_core.sv @@
// ----------------------------------------------------------------------------
// adaptive_upload_limit_estimator_core
// Estimates a sustainable upload limit from slot busy share, one request per
// throttler loop.
//
// Input channel (in_valid/in_ready): one request per loop with slot counts,
// the ms tick and the measured and allowed rates. in_ready is high only while
// the sequencer is idle. Output channel (out_valid/out_ready): one result per
// request, held in an output register until taken.
// Config channel (cfg_valid/cfg_ready): always ready, write when idle.
// In auto mode a request passes the bit-serial fraction divider, then up to
// seven sequencer steps around the shared 32-bit adder once the divider is
// seen done, then the output load; a request with no sendable slot skips the
// divider. Manual mode goes straight to the output load. The next request is
// taken the cycle after the result is loaded, so a new request is only taken
// once the previous one has reached the output step.
// If the receiver stalls, the finished result waits in the output stage and
// the next request is accepted; its own result waits until the register
// frees. Reset clears all estimator state and loads the register defaults.
// ----------------------------------------------------------------------------
module adaptive_upload_limit_estimator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [aule_pkg::SLOT_W-1:0]            busy_count,
	input  logic [aule_pkg::SLOT_W-1:0]            sendable_count,
	input  logic [aule_pkg::SLOT_W-1:0]            slot_count,
	input  logic [aule_pkg::RATE_W-1:0]            now_ms,
	input  logic [aule_pkg::RATE_W-1:0]            measured_rate,
	input  logic [aule_pkg::RATE_W-1:0]            allowed_rate,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [aule_pkg::RATE_W-1:0]            effective_rate,
	output logic [aule_pkg::RATE_W-1:0]            estimated_rate,
	output logic signed [aule_pkg::LEVEL_W-1:0]    busy_level_out,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [aule_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [aule_pkg::WARMUP_W-1:0]          cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DIV   = 10'b0000000010,
		ST_LEVEL = 10'b0000000100,
		ST_START = 10'b0000001000,
		ST_TIME  = 10'b0000010000,
		ST_RUN   = 10'b0000100000,
		ST_ADJ   = 10'b0001000000,
		ST_CAP   = 10'b0010000000,
		ST_CLAMP = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic                              auto_mode_q;
	logic [aule_pkg::WARMUP_W-1:0]     warmup_q;
	logic [aule_pkg::SLOT_W-1:0]       start_slots_q;

	// estimator state
	logic signed [aule_pkg::LEVEL_W-1:0] busy_level_q;
	logic [aule_pkg::RATE_W-1:0]       est_q;
	logic [aule_pkg::RATE_W-1:0]       start_time_q;
	logic                              started_q;
	logic [aule_pkg::RUN_W-1:0]        up_run_q;
	logic [aule_pkg::RUN_W-1:0]        down_run_q;
	logic [aule_pkg::CNT_W-1:0]        change_q;
	logic [aule_pkg::CNT_W-1:0]        loop_q;

	// request and scratch
	logic [aule_pkg::SLOT_W-1:0]       busy_q;
	logic [aule_pkg::SLOT_W-1:0]       send_q;
	logic [aule_pkg::SLOT_W-1:0]       slots_q;
	logic [aule_pkg::RATE_W-1:0]       now_q;
	logic [aule_pkg::RATE_W-1:0]       meas_q;
	logic [aule_pkg::RATE_W-1:0]       allowed_q;
	logic [aule_pkg::RATE_W-1:0]       elapsed_q;
	logic [aule_pkg::RATE_W:0]         sum_q;
	logic [aule_pkg::DELTA_W-1:0]      delta_q;
	logic                              down_q;
	// set once the warm-up test passes for this request
	logic                              warm_q;

	// output stage
	logic                              out_valid_q;
	logic [aule_pkg::RATE_W-1:0]       eff_out_q;
	logic [aule_pkg::RATE_W-1:0]       est_out_q;
	logic signed [aule_pkg::LEVEL_W-1:0] level_out_q;

	logic                              in_acc;
	logic                              out_load;
	logic [aule_pkg::SLOT_W-1:0]       busy_sat;
	logic [aule_pkg::SLOT_W-1:0]       send_sat;
	logic [aule_pkg::SLOT_W-1:0]       slots_sat;
	logic [aule_pkg::SLOT_W-1:0]       busy_min;
	logic                              div_start;
	logic [aule_pkg::FRAC_W-1:0]       frac;
	aule_pkg::div_stat_t               div_st;
	aule_pkg::addsub_req_t             alu_req;
	logic [aule_pkg::RATE_W:0]         alu_res;
	logic                              restart;
	logic [aule_pkg::RUN_W-1:0]        down_next;
	logic [aule_pkg::RUN_W-1:0]        up_next;

	function automatic logic sendable_eq_busy();
		return send_q == busy_q;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign busy_sat  = (busy_count > aule_pkg::SLOT_COUNT_MAX) ?
		aule_pkg::SLOT_COUNT_MAX : busy_count;
	assign send_sat  = (sendable_count > aule_pkg::SLOT_COUNT_MAX) ?
		aule_pkg::SLOT_COUNT_MAX : sendable_count;
	assign slots_sat = (slot_count > aule_pkg::SLOT_COUNT_MAX) ?
		aule_pkg::SLOT_COUNT_MAX : slot_count;
	assign busy_min  = (busy_sat > send_sat) ? send_sat : busy_sat;

	assign div_start = in_acc && auto_mode_q && (send_sat != '0);

	aule_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({busy_min, aule_pkg::FRAC_SHIFT'(0)}),
		.divisor  (send_sat),
		.quotient (frac),
		.stat     (div_st)
	);

	// operand select for the shared adder
	always_comb begin
		alu_req.sub = 1'b1;
		alu_req.a   = est_q;
		alu_req.b   = allowed_q;
		case (state_q)
			ST_START: begin
				alu_req.a = now_q;
				alu_req.b = start_time_q;
			end
			ST_TIME: begin
				alu_req.a = elapsed_q;
				alu_req.b = aule_pkg::RATE_W'(warmup_q);
			end
			ST_ADJ: begin
				alu_req.sub = down_q;
				alu_req.a   = est_q;
				alu_req.b   = aule_pkg::RATE_W'(delta_q);
			end
			ST_CAP: begin
				alu_req.a = allowed_q;
				alu_req.b = sum_q[aule_pkg::RATE_W-1:0];
			end
			default: begin
				alu_req.sub = 1'b1;
			end
		endcase
	end

	aule_addsub u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign restart = (change_q > aule_pkg::CHG_LIMIT) ||
		((change_q > aule_pkg::CHG_LIMIT_MID) && (loop_q > aule_pkg::LOOP_LIMIT_MID)) ||
		(loop_q > aule_pkg::LOOP_LIMIT);
	assign down_next = restart ? '0 :
		((down_run_q != aule_pkg::RUN_MAX) ? down_run_q + 1'b1 : down_run_q);
	assign up_next   = restart ? '0 :
		((up_run_q != aule_pkg::RUN_MAX) ? up_run_q + 1'b1 : up_run_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q   <= 1'b1;
			warmup_q      <= aule_pkg::WARMUP_RESET;
			start_slots_q <= aule_pkg::START_SLOTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				aule_pkg::CFG_AUTO_MODE:   auto_mode_q   <= cfg_data[0];
				aule_pkg::CFG_WARMUP_MS:   warmup_q      <= cfg_data;
				aule_pkg::CFG_START_SLOTS: start_slots_q <= cfg_data[aule_pkg::SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_level_q <= '0;
			est_q        <= '0;
			start_time_q <= '0;
			started_q    <= 1'b0;
			up_run_q     <= '0;
			down_run_q   <= '0;
			change_q     <= '0;
			loop_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!auto_mode_q) begin
							state_q <= ST_OUT;
						end else begin
							loop_q  <= aule_pkg::inc_sat(loop_q);
							state_q <= (send_sat != '0) ? ST_DIV : ST_START;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					if ((busy_q > aule_pkg::BUSY_FEW) && (frac > aule_pkg::FRAC_HIGH) &&
					    (busy_level_q < aule_pkg::LEVEL_MAX)) begin
						busy_level_q <= busy_level_q + 9'sd1;
						change_q     <= aule_pkg::inc_sat(change_q);
					end else if (((busy_q <= aule_pkg::BUSY_FEW) ||
					              (frac < aule_pkg::FRAC_LOW)) &&
					             (busy_level_q > aule_pkg::LEVEL_MIN)) begin
						busy_level_q <= busy_level_q - 9'sd1;
						change_q     <= aule_pkg::inc_sat(change_q);
					end
					state_q <= ST_START;
				end
				ST_START: begin
					if (!started_q) begin
						if (slots_q >= start_slots_q) begin
							start_time_q <= now_q;
							started_q    <= 1'b1;
						end
						state_q <= ST_CLAMP;
					end else begin
						state_q <= ST_TIME;
					end
				end
				ST_TIME: begin
					// no borrow means warm-up is over
					state_q <= alu_res[aule_pkg::RATE_W] ? ST_CLAMP : ST_RUN;
				end
				ST_RUN: begin
					state_q <= ST_CLAMP;
					if (est_q == '0) begin
						if (busy_level_q >= aule_pkg::LEVEL_HIGH) begin
							est_q        <= meas_q;
							busy_level_q <= aule_pkg::LEVEL_RESTART;
							change_q     <= '0;
							loop_q       <= '0;
						end
					end else if (busy_level_q > aule_pkg::LEVEL_HIGH) begin
						down_run_q <= down_next;
						delta_q    <= aule_pkg::step_delta(down_next);
						down_q     <= 1'b1;
						state_q    <= ST_ADJ;
					end else if (busy_level_q < aule_pkg::LEVEL_LOW) begin
						up_run_q <= up_next;
						delta_q  <= aule_pkg::step_delta(up_next);
						down_q   <= 1'b0;
						state_q  <= ST_ADJ;
					end
				end
				ST_ADJ: begin
					busy_level_q <= '0;
					change_q     <= '0;
					loop_q       <= '0;
					if (down_q) begin
						up_run_q <= '0;
						// lowered value must stay at or above the floor
						if (!alu_res[aule_pkg::RATE_W] &&
						    (alu_res[aule_pkg::RATE_W-1:10] != '0)) begin
							est_q <= alu_res[aule_pkg::RATE_W-1:0];
						end else if (est_q > aule_pkg::EST_FLOOR) begin
							est_q <= aule_pkg::EST_FLOOR;
						end
						state_q <= ST_CLAMP;
					end else begin
						down_run_q <= '0;
						sum_q      <= alu_res;
						state_q    <= ST_CAP;
					end
				end
				ST_CAP: begin
					if (sum_q[aule_pkg::RATE_W] || alu_res[aule_pkg::RATE_W]) begin
						est_q <= allowed_q;
					end else begin
						est_q <= sum_q[aule_pkg::RATE_W-1:0];
					end
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if ((sendable_eq_busy()) && (slots_q != '0) &&
					    (busy_level_q < aule_pkg::LEVEL_ALL_BUSY)) begin
						busy_level_q <= aule_pkg::LEVEL_ALL_BUSY;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture and the warm-path limits
	always_ff @(posedge clk) begin
		if (in_acc) begin
			busy_q    <= busy_min;
			send_q    <= send_sat;
			slots_q   <= slots_sat;
			now_q     <= now_ms;
			meas_q    <= measured_rate;
			allowed_q <= allowed_rate;
		end else if (state_q == ST_START) begin
			elapsed_q <= alu_res[aule_pkg::RATE_W-1:0];
		end else if ((state_q == ST_CLAMP) && warm_q) begin
			if (allowed_q > est_q) begin
				allowed_q <= est_q;
			end
		end
		if (out_load) begin
			eff_out_q   <= allowed_q;
			est_out_q   <= est_q;
			level_out_q <= busy_level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= 1'b0;
		end else if (in_acc) begin
			warm_q <= 1'b0;
		end else if (state_q == ST_TIME) begin
			warm_q <= !alu_res[aule_pkg::RATE_W];
		end
	end

	assign out_valid      = out_valid_q;
	assign effective_rate = eff_out_q;
	assign estimated_rate = est_out_q;
	assign busy_level_out = level_out_q;

`ifndef SYNTH
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_level_q <= aule_pkg::LEVEL_MAX) && (busy_level_q >= aule_pkg::LEVEL_MIN))
		else $error("busy level out of range");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result loaded outside the output step");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV))
		else $error("divider finished while sequencer not waiting");

	a_est_floor: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ADJ) && down_q && (est_q >= aule_pkg::EST_FLOOR))
		|=> (est_q >= aule_pkg::EST_FLOOR))
		else $error("lowered estimate fell below the floor");
`endif

endmodule

@@ verif/aule_rate_checker.sv @@
// ----------------------------------------------------------------------------
// aule_rate_checker
// Watches the request, result and register channels of the upload limit
// estimator, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module aule_rate_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [aule_pkg::SLOT_W-1:0]         busy_count,
	input  logic [aule_pkg::SLOT_W-1:0]         sendable_count,
	input  logic [aule_pkg::SLOT_W-1:0]         slot_count,
	input  logic [aule_pkg::RATE_W-1:0]         now_ms,
	input  logic [aule_pkg::RATE_W-1:0]         measured_rate,
	input  logic [aule_pkg::RATE_W-1:0]         allowed_rate,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [aule_pkg::RATE_W-1:0]         effective_rate,
	input  logic [aule_pkg::RATE_W-1:0]         estimated_rate,
	input  logic signed [aule_pkg::LEVEL_W-1:0] busy_level_out,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [aule_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aule_pkg::WARMUP_W-1:0]       cfg_data,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  n_checked,
	output int                                  n_set,
	output int                                  n_lowered,
	output int                                  n_raised
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [aule_pkg::RATE_W-1:0]  eff;
		logic [aule_pkg::RATE_W-1:0]  est;
		logic [aule_pkg::LEVEL_W-1:0] lvl;
	} limit_result_t;

	limit_result_t expected_rates[$];
	limit_result_t want;
	limit_result_t fresh;

	// configuration copy
	bit                            auto_on;
	logic [aule_pkg::WARMUP_W-1:0] warm_ms;
	logic [aule_pkg::SLOT_W-1:0]   need_slots;

	// estimator state copy
	int                            level;
	logic [aule_pkg::RATE_W-1:0]   est_rate;
	logic [aule_pkg::RATE_W-1:0]   start_tick;
	bit                            started;
	logic [aule_pkg::RUN_W-1:0]    up_run;
	logic [aule_pkg::RUN_W-1:0]    dn_run;
	logic [aule_pkg::CNT_W-1:0]    change_cnt;
	logic [aule_pkg::CNT_W-1:0]    loop_cnt;

	function automatic logic [aule_pkg::SLOT_W-1:0] clamp_slots(
		input logic [aule_pkg::SLOT_W-1:0] v);
		return (v > 7'd64) ? 7'd64 : v;
	endfunction

	function automatic logic [aule_pkg::CNT_W-1:0] bump16(input logic [aule_pkg::CNT_W-1:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [aule_pkg::RATE_W-1:0] run_delta(
		input logic [aule_pkg::RUN_W-1:0] run);
		logic [3:0] idx;
		logic [aule_pkg::RATE_W-1:0] d;
		idx = (run > 4'd8) ? 4'd8 : run;
		case (idx)
			4'd0, 4'd1: d = 32'd50;
			4'd2:       d = 32'd128;
			default:    d = 32'd256 << (idx - 4'd3);
		endcase
		// the top of the table grows by 256 per step, not by doubling
		if (idx >= 4'd5)
			d = 32'd512 + 32'd256 * (idx - 4'd4);
		return d;
	endfunction

	function automatic bit runs_restart(input logic [aule_pkg::CNT_W-1:0] chg,
		input logic [aule_pkg::CNT_W-1:0] loops);
		return chg > 16'd500 || (chg > 16'd300 && loops > 16'd1000) || loops > 16'd2000;
	endfunction

	task automatic predict_limit(
		input  logic [aule_pkg::SLOT_W-1:0] b_raw,
		input  logic [aule_pkg::SLOT_W-1:0] s_raw,
		input  logic [aule_pkg::SLOT_W-1:0] n_raw,
		input  logic [aule_pkg::RATE_W-1:0] now,
		input  logic [aule_pkg::RATE_W-1:0] meas,
		input  logic [aule_pkg::RATE_W-1:0] allow_raw,
		output limit_result_t               res
	);
		logic [aule_pkg::SLOT_W-1:0] snd;
		logic [aule_pkg::SLOT_W-1:0] bsy;
		logic [aule_pkg::SLOT_W-1:0] nsl;
		logic [aule_pkg::RATE_W-1:0] allow;
		logic [aule_pkg::RATE_W-1:0] delta;
		logic [aule_pkg::RATE_W-1:0] span;
		logic [aule_pkg::RATE_W:0]   sum;
		int                          share;
		snd = clamp_slots(s_raw);
		bsy = clamp_slots(b_raw);
		nsl = clamp_slots(n_raw);
		allow = allow_raw;
		if (bsy > snd)
			bsy = snd;
		if (auto_on) begin
			loop_cnt = bump16(loop_cnt);
			if (snd != 0) begin
				share = (int'(bsy) * 32) / int'(snd);
				if (bsy > 2 && share > 24 && level < 255) begin
					level++;
					change_cnt = bump16(change_cnt);
				end else if ((bsy <= 2 || share < 8) && level > -255) begin
					level--;
					change_cnt = bump16(change_cnt);
				end
			end
			span = now - start_tick;
			if (!started) begin
				if (nsl >= need_slots) begin
					start_tick = now;
					started = 1'b1;
				end
			end else if (span >= {12'd0, warm_ms}) begin
				if (est_rate == 0) begin
					if (level >= 250) begin
						est_rate = meas;
						level = -200;
						change_cnt = '0;
						loop_cnt = '0;
						n_set++;
					end
				end else if (level > 250) begin
					if (runs_restart(change_cnt, loop_cnt))
						dn_run = '0;
					else if (dn_run != 4'd15)
						dn_run++;
					delta = run_delta(dn_run);
					// never below the floor; an estimate already under it stays put
					if (est_rate < delta + 32'd1024)
						delta = (est_rate > 32'd1024) ? est_rate - 32'd1024 : 32'd0;
					est_rate = est_rate - delta;
					up_run = '0;
					level = 0;
					change_cnt = '0;
					loop_cnt = '0;
					n_lowered++;
				end else if (level < -250) begin
					if (runs_restart(change_cnt, loop_cnt))
						up_run = '0;
					else if (up_run != 4'd15)
						up_run++;
					sum = {1'b0, est_rate} + {1'b0, run_delta(up_run)};
					if (sum > {1'b0, allow})
						sum = {1'b0, allow};
					est_rate = sum[aule_pkg::RATE_W-1:0];
					dn_run = '0;
					level = 0;
					change_cnt = '0;
					loop_cnt = '0;
					n_raised++;
				end
				if (allow > est_rate)
					allow = est_rate;
			end
			if (snd == bsy && nsl != 0 && level < 125)
				level = 125;
		end
		res.eff = allow;
		res.est = est_rate;
		res.lvl = level[aule_pkg::LEVEL_W-1:0];
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		n_checked = 0;
		n_set = 0;
		n_lowered = 0;
		n_raised = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_on = 1'b1;
			warm_ms = aule_pkg::WARMUP_RESET;
			need_slots = aule_pkg::START_SLOTS_RESET;
			level = 0;
			est_rate = '0;
			start_tick = '0;
			started = 1'b0;
			up_run = '0;
			dn_run = '0;
			change_cnt = '0;
			loop_cnt = '0;
			expected_rates.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					aule_pkg::CFG_AUTO_MODE:   auto_on = cfg_data[0];
					aule_pkg::CFG_WARMUP_MS:   warm_ms = cfg_data;
					aule_pkg::CFG_START_SLOTS: need_slots = cfg_data[aule_pkg::SLOT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_rates.size() == 0) begin
					report_mismatch($sformatf("result with no request pending (eff %0d est %0d)",
						effective_rate, estimated_rate));
				end else begin
					want = expected_rates.pop_front();
					n_checked++;
					if (effective_rate !== want.eff)
						report_mismatch($sformatf("effective_rate %0d, expected %0d",
							effective_rate, want.eff));
					if (estimated_rate !== want.est)
						report_mismatch($sformatf("estimated_rate %0d, expected %0d",
							estimated_rate, want.est));
					if (busy_level_out !== want.lvl)
						report_mismatch($sformatf("busy_level_out %0d, expected %0d",
							$signed(busy_level_out), $signed(want.lvl)));
				end
			end
			if (in_valid && in_ready) begin
				predict_limit(busy_count, sendable_count, slot_count, now_ms,
					measured_rate, allowed_rate, fresh);
				expected_rates.push_back(fresh);
			end
			pending <= expected_rates.size();
		end
	end

endmodule

@@ verif/tb_adaptive_upload_limit_estimator_core.sv @@
// ----------------------------------------------------------------------------
// tb_adaptive_upload_limit_estimator_core
// Drives throttler-loop requests and register writes into the estimator core,
// with random idle bursts on the request and result channels; a checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_adaptive_upload_limit_estimator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 30;
	localparam int STALL_LIMIT   = 1000;

	typedef enum int {
		SHARE_HIGH,
		SHARE_LOW,
		SHARE_ANY
	} load_mode_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [aule_pkg::SLOT_W-1:0]         busy_count = '0;
	logic [aule_pkg::SLOT_W-1:0]         sendable_count = '0;
	logic [aule_pkg::SLOT_W-1:0]         slot_count = '0;
	logic [aule_pkg::RATE_W-1:0]         now_ms = '0;
	logic [aule_pkg::RATE_W-1:0]         measured_rate = '0;
	logic [aule_pkg::RATE_W-1:0]         allowed_rate = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [aule_pkg::RATE_W-1:0]         effective_rate;
	logic [aule_pkg::RATE_W-1:0]         estimated_rate;
	logic signed [aule_pkg::LEVEL_W-1:0] busy_level_out;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [aule_pkg::CFG_IDX_W-1:0]      cfg_index = aule_pkg::CFG_AUTO_MODE;
	logic [aule_pkg::WARMUP_W-1:0]       cfg_data = '0;

	int mismatches;
	int pending;
	int n_checked;
	int n_set;
	int n_lowered;
	int n_raised;

	int          idle_pct = 0;
	bit          tail_calm = 1'b0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int          n_requests = 0;
	logic [31:0] tick = '0;

	always #1 clk = ~clk;

	adaptive_upload_limit_estimator_core dut (.*);

	aule_rate_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.busy_count     (busy_count),
		.sendable_count (sendable_count),
		.slot_count     (slot_count),
		.now_ms         (now_ms),
		.measured_rate  (measured_rate),
		.allowed_rate   (allowed_rate),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.effective_rate (effective_rate),
		.estimated_rate (estimated_rate),
		.busy_level_out (busy_level_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.n_checked      (n_checked),
		.n_set          (n_set),
		.n_lowered      (n_lowered),
		.n_raised       (n_raised)
	);

	// result side backpressure: random bursts with out_ready held low
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2, 3, 4: return $urandom_range(0, 4000);
			default: return $urandom;
		endcase
	endfunction

	task automatic advance_tick();
		case ($urandom_range(0, 59))
			0:       tick = $urandom;
			1:       tick = 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: tick = tick + $urandom_range(0, 40);
		endcase
	endtask

	// leaves in_valid high so back-to-back requests need no toggle
	task automatic send_request(
		input logic [aule_pkg::SLOT_W-1:0] b,
		input logic [aule_pkg::SLOT_W-1:0] s,
		input logic [aule_pkg::SLOT_W-1:0] n,
		input logic [aule_pkg::RATE_W-1:0] now,
		input logic [aule_pkg::RATE_W-1:0] meas,
		input logic [aule_pkg::RATE_W-1:0] allow
	);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		busy_count <= b;
		sendable_count <= s;
		slot_count <= n;
		now_ms <= now;
		measured_rate <= meas;
		allowed_rate <= allow;
		do @(posedge clk); while (!in_ready);
		n_requests++;
	endtask

	task automatic cfg_write(input logic [aule_pkg::CFG_IDX_W-1:0] idx,
		input logic [aule_pkg::WARMUP_W-1:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_request(input load_mode_t mode);
		logic [aule_pkg::SLOT_W-1:0] b;
		logic [aule_pkg::SLOT_W-1:0] s;
		logic [aule_pkg::SLOT_W-1:0] n;
		int lo;
		case (mode)
			SHARE_HIGH: begin
				s = aule_pkg::SLOT_W'($urandom_range(3, 64));
				lo = (25 * int'(s) + 31) / 32;
				if (lo < 3)
					lo = 3;
				b = aule_pkg::SLOT_W'($urandom_range(lo, int'(s)));
				n = aule_pkg::SLOT_W'($urandom_range(0, 64));
			end
			SHARE_LOW: begin
				// keep busy below sendable so the all-busy jump never fires
				if ($urandom_range(0, 1) == 0) begin
					b = aule_pkg::SLOT_W'($urandom_range(0, 2));
					s = aule_pkg::SLOT_W'($urandom_range(int'(b) + 1, 64));
				end else begin
					s = aule_pkg::SLOT_W'($urandom_range(16, 64));
					b = aule_pkg::SLOT_W'($urandom_range(0, (8 * int'(s) - 1) / 32));
				end
				n = aule_pkg::SLOT_W'($urandom_range(0, 127));
			end
			default: begin
				b = aule_pkg::SLOT_W'($urandom_range(0, 127));
				s = aule_pkg::SLOT_W'($urandom_range(0, 127));
				n = aule_pkg::SLOT_W'($urandom_range(0, 127));
			end
		endcase
		advance_tick();
		send_request(b, s, n, tick, pick_rate(), pick_rate());
	endtask

	task automatic run_segments(input int count);
		int left;
		int len;
		load_mode_t mode;
		left = count;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					mode = SHARE_HIGH;
					len = $urandom_range(40, 220);
				end
				4, 5, 6, 7: begin
					mode = SHARE_LOW;
					len = $urandom_range(30, 280);
				end
				default: begin
					mode = SHARE_ANY;
					len = $urandom_range(1, 12);
				end
			endcase
			if (len > left)
				len = left;
			idle_pct = tail_calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : 25);
			repeat (len) random_request(mode);
			left -= len;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 25;

		// highest start threshold first, so the start latch is seen late
		cfg_write(aule_pkg::CFG_START_SLOTS, 20'd64, 1'b1);
		send_request(7'd0,   7'd0,   7'd0,   32'hFFFF_FFFF, 32'd0,         32'hFFFF_FFFF);
		send_request(7'd127, 7'd127, 7'd63,  32'd5,         32'hFFFF_FFFF, 32'd0);
		send_request(7'd100, 7'd10,  7'd5,   32'd6,         32'd1,         32'd1);
		send_request(7'd2,   7'd64,  7'd0,   32'd7,         32'd500,       32'd700);
		send_request(7'd3,   7'd4,   7'd0,   32'd8,         32'd500,       32'd700);
		send_request(7'd8,   7'd10,  7'd0,   32'd9,         32'd500,       32'd700);
		send_request(7'd3,   7'd13,  7'd0,   32'd10,        32'd500,       32'd700);
		send_request(7'd3,   7'd12,  7'd0,   32'd11,        32'd500,       32'd700);
		send_request(7'd0,   7'd1,   7'd1,   32'd12,        32'd500,       32'd700);
		send_request(7'd64,  7'd64,  7'd0,   32'd13,        32'd500,       32'd700);
		// oversized slot count saturates to the threshold; start at tick zero
		send_request(7'd127, 7'd127, 7'd127, 32'd0,         32'h8000_0000, 32'h7FFF_FFFF);
		send_request(7'd5,   7'd20,  7'd10,  32'd59999,     32'd12345,     32'd99999);
		send_request(7'd5,   7'd20,  7'd10,  32'd60000,     32'd12345,     32'd99999);
		send_request(7'd5,   7'd20,  7'd10,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(7'h55,  7'h2A,  7'h55,  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		send_request(7'h2A,  7'h55,  7'h2A,  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(7'd0,   7'd0,   7'd64,  32'd0,         32'd0,         32'd0);
		drain_results();

		// manual mode holds all state
		cfg_write(aule_pkg::CFG_AUTO_MODE, 20'd0, 1'b1);
		repeat (12) random_request(SHARE_ANY);
		repeat (12) random_request(SHARE_HIGH);
		drain_results();

		cfg_write(aule_pkg::CFG_AUTO_MODE, 20'd1, 1'b0);
		cfg_write(aule_pkg::CFG_WARMUP_MS, 20'd0, 1'b0);
		cfg_write(aule_pkg::CFG_START_SLOTS, 20'd1, 1'b1);
		run_segments(500);
		drain_results();

		cfg_write(aule_pkg::CFG_WARMUP_MS, 20'd600000, 1'b1);
		run_segments(200);
		drain_results();

		cfg_write(aule_pkg::CFG_WARMUP_MS, 20'd524287, 1'b0);
		cfg_write(aule_pkg::CFG_START_SLOTS, 20'd3, 1'b1);
		run_segments(200);
		drain_results();

		cfg_write(aule_pkg::CFG_AUTO_MODE, 20'd0, 1'b1);
		repeat (30) random_request(SHARE_ANY);
		drain_results();

		cfg_write(aule_pkg::CFG_AUTO_MODE, 20'd1, 1'b0);
		cfg_write(aule_pkg::CFG_WARMUP_MS, aule_pkg::WARMUP_W'($urandom_range(0, 2000)), 1'b1);
		run_segments(250);
		drain_results();

		tail_calm = 1'b1;
		idle_pct = 0;
		cfg_write(aule_pkg::CFG_WARMUP_MS, 20'd0, 1'b1);
		run_segments(150);
		drain_results();

		$display("Checked %0d results from %0d requests", n_checked, n_requests);
		$display("Estimate taken %0d, lowered %0d, raised %0d times; %s",
			n_set, n_lowered, n_raised,
			"manual mode, warm-up of 0 to 600000 ms, start thresholds of 1, 3 and 64");
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
